/* sv/rse_pkg.sv */
// ----------------------------------------------------------------------------
// rse_pkg
// Shared types, register map and GF(2^m) helpers for the systematic
// Reed-Solomon encoder.
// ----------------------------------------------------------------------------
package rse_pkg;

    // Field limits and defaults
    localparam int MAX_SYMBOL_BITS  = 8;
    localparam int RSE_MAX_PARITY   = 32;
    localparam int SYM_W            = 8;
    localparam int POLY_W           = 9;
    localparam int RSE_ADDR_W       = 5;
    localparam int RSE_DATA_W       = 32;

    // Register map, index of each 32-bit word
    localparam logic [2:0] REG_SYMBOL_BITS   = 3'd0;
    localparam logic [2:0] REG_FIELD_POLY    = 3'd1;
    localparam logic [2:0] REG_PARITY_COUNT  = 3'd2;
    localparam logic [2:0] REG_MESSAGE_LEN   = 3'd3;
    localparam logic [2:0] REG_FIRST_ROOT    = 3'd4;

    // Reset values of the registers
    localparam logic [3:0] RST_SYMBOL_BITS   = 4'd8;
    localparam logic [8:0] RST_FIELD_POLY    = 9'h11d;
    localparam logic [5:0] RST_PARITY_COUNT  = 6'd16;
    localparam logic [7:0] RST_MESSAGE_LEN   = 8'd239;
    localparam logic [7:0] RST_FIRST_ROOT    = 8'd0;

    typedef logic [SYM_W-1:0]  sym_t;
    typedef logic [POLY_W-1:0] poly_t;

    // Multiply by alpha (x): shift up, reduce by the field polynomial, mask to m bits
    function automatic sym_t gf_xtime(sym_t a, logic [3:0] m, poly_t poly);
        logic [POLY_W-1:0] sh;
        logic [POLY_W-1:0] mask;
        mask = (POLY_W'(1) << m) - POLY_W'(1);
        sh   = {a, 1'b0};
        if (sh[m]) begin
            sh = sh ^ poly;
        end
        return sym_t'(sh & mask);
    endfunction

    // Shift-and-add GF(2^m) multiply, one bit of b per step
    function automatic sym_t gf_mul(sym_t a, sym_t b, logic [3:0] m, poly_t poly);
        sym_t              acc;
        sym_t              r;
        logic [POLY_W-1:0] mask;
        mask = (POLY_W'(1) << m) - POLY_W'(1);
        acc  = a & sym_t'(mask);
        r    = '0;
        for (int i = 0; i < MAX_SYMBOL_BITS; i++) begin
            if ((i < int'(m)) && b[i]) begin
                r = r ^ acc;
            end
            acc = gf_xtime(acc, m, poly);
        end
        return r;
    endfunction

endpackage

/* sv/rs_systematic_encoder.sv */
// An accepted data symbol is registered in in_data_reg and then in m_sym_reg before it is on m_*.
// Throughput: one data symbol per cycle while the output accepts; after the last data symbol
// of a codeword the input stalls while the P parity symbols (P = parity_count, clamped to
// 2..MAX_PARITY) drain through the single output stream that carries both data and parity.
// Reset, and every write to a mapped register, rebuilds the generator (root walk, then
// P root factors) with s_ready low; the shift register and symbol count clear.
// ----------------------------------------------------------------------------
// rs_systematic_encoder
// Systematic Reed-Solomon encoder over GF(2^m), m = 3..8. Data symbols pass
// through while a parallel LFSR divides by the generator; the remainder is
// then emitted as parity, highest degree first, with block_last on the final
// parity symbol.
// ----------------------------------------------------------------------------
module rs_systematic_encoder #(
    parameter int MAX_PARITY = rse_pkg::RSE_MAX_PARITY
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  rse_pkg::sym_t                    s_data_symbol,
    // result channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output rse_pkg::sym_t                    m_out_symbol,
    output logic                             m_is_parity,
    output logic                             m_block_last,
    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rse_pkg::RSE_ADDR_W-1:0]   paddr,
    input  logic [rse_pkg::RSE_DATA_W-1:0]   pwdata,
    output logic [rse_pkg::RSE_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import rse_pkg::*;

    localparam int PAR_W = $clog2(MAX_PARITY + 1);
    localparam int IDX_W = $clog2(MAX_PARITY);

    typedef enum logic [1:0] {ST_POW, ST_GEN, ST_RUN} state_t;

    // Configuration registers
    logic [3:0]  sbits_reg;
    poly_t       fpoly_reg;
    logic [5:0]  pcount_reg;
    logic [7:0]  mlen_reg;
    logic [7:0]  fcr_reg;

    // Generator build
    state_t      state_reg;
    logic [7:0]  step_reg;
    sym_t        root_reg;
    sym_t        gen_reg  [0:MAX_PARITY];
    sym_t        gen_next [0:MAX_PARITY];

    // Encoder datapath
    sym_t        lfsr_reg  [0:MAX_PARITY-1];
    sym_t        lfsr_next [0:MAX_PARITY-1];
    sym_t        pbuf_reg  [0:MAX_PARITY-1];
    logic [PAR_W-1:0] pcnt_reg;
    logic [7:0]  taken_reg;
    logic        in_valid_reg;
    sym_t        in_data_reg;
    logic        m_valid_reg;
    sym_t        m_sym_reg;
    logic        m_par_reg;
    logic        m_last_reg;

    logic [3:0]       m_eff;
    logic [PAR_W-1:0] p_eff;
    logic [IDX_W-1:0] p_last;
    logic [7:0]       k_eff;
    sym_t             sym_mask;
    sym_t             d_in;
    sym_t             fb;
    logic [7:0]       taken_inc;
    logic             word_end;
    logic             out_free;
    logic             drain;
    logic             proc;
    logic             run;
    logic             cfg_wr;
    logic             cfg_hit;
    logic [2:0]       reg_idx;

    // Effective settings, clamped into their legal ranges
    always_comb begin
        if (sbits_reg < 4'd3) begin
            m_eff = 4'd3;
        end else if (sbits_reg > 4'(MAX_SYMBOL_BITS)) begin
            m_eff = 4'(MAX_SYMBOL_BITS);
        end else begin
            m_eff = sbits_reg;
        end
        if (pcount_reg < 6'd2) begin
            p_eff = PAR_W'(2);
        end else if (int'(pcount_reg) > MAX_PARITY) begin
            p_eff = PAR_W'(MAX_PARITY);
        end else begin
            p_eff = PAR_W'(pcount_reg);
        end
        k_eff    = (mlen_reg == 8'd0) ? 8'd1 : mlen_reg;
        p_last   = IDX_W'(p_eff - PAR_W'(1));
        sym_mask = sym_t'((POLY_W'(1) << m_eff) - POLY_W'(1));
    end

    // Handshake control
    assign run       = (state_reg == ST_RUN);
    assign out_free  = !m_valid_reg || m_ready;
    assign drain     = (pcnt_reg != '0);
    assign proc      = in_valid_reg && out_free && !drain && run;
    assign s_ready   = run && (!in_valid_reg || proc);
    assign d_in      = in_data_reg & sym_mask;
    assign taken_inc = taken_reg + 8'd1;
    assign word_end  = (taken_inc >= k_eff);

    // Generator step: multiply g(x) by (x - root)
    always_comb begin
        gen_next[0] = gf_mul(root_reg, gen_reg[0], m_eff, fpoly_reg);
        for (int j = 1; j <= MAX_PARITY; j++) begin
            gen_next[j] = gen_reg[j-1] ^ gf_mul(root_reg, gen_reg[j], m_eff, fpoly_reg);
        end
    end

    // LFSR step, all taps in parallel
    always_comb begin
        fb = d_in ^ lfsr_reg[p_last];
        lfsr_next[0] = gf_mul(fb, gen_reg[0], m_eff, fpoly_reg);
        for (int j = 1; j < MAX_PARITY; j++) begin
            if (j < int'(p_eff)) begin
                lfsr_next[j] = lfsr_reg[j-1] ^ gf_mul(fb, gen_reg[j], m_eff, fpoly_reg);
            end else begin
                lfsr_next[j] = '0;
            end
        end
    end

    // Register decode
    assign reg_idx = paddr[RSE_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_hit = cfg_wr && (reg_idx <= REG_FIRST_ROOT);
    assign pready  = 1'b1;

    always_comb begin
        unique case (reg_idx)
            REG_SYMBOL_BITS:  prdata = RSE_DATA_W'(sbits_reg);
            REG_FIELD_POLY:   prdata = RSE_DATA_W'(fpoly_reg);
            REG_PARITY_COUNT: prdata = RSE_DATA_W'(pcount_reg);
            REG_MESSAGE_LEN:  prdata = RSE_DATA_W'(mlen_reg);
            REG_FIRST_ROOT:   prdata = RSE_DATA_W'(fcr_reg);
            default:          prdata = '0;
        endcase
    end

    // State, datapath and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sbits_reg    <= RST_SYMBOL_BITS;
            fpoly_reg    <= RST_FIELD_POLY;
            pcount_reg   <= RST_PARITY_COUNT;
            mlen_reg     <= RST_MESSAGE_LEN;
            fcr_reg      <= RST_FIRST_ROOT;
            state_reg    <= ST_POW;
            step_reg     <= '0;
            root_reg     <= sym_t'(1);
            for (int j = 0; j <= MAX_PARITY; j++) begin
                gen_reg[j] <= (j == 0) ? sym_t'(1) : '0;
            end
            for (int j = 0; j < MAX_PARITY; j++) begin
                lfsr_reg[j] <= '0;
            end
            taken_reg    <= '0;
            pcnt_reg     <= '0;
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            // input register
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
                in_data_reg  <= s_data_symbol;
            end else if (proc) begin
                in_valid_reg <= 1'b0;
            end

            // output register: parity drain first, then data
            if (out_free) begin
                if (drain) begin
                    m_valid_reg <= 1'b1;
                    m_sym_reg   <= pbuf_reg[p_last];
                    m_par_reg   <= 1'b1;
                    m_last_reg  <= (pcnt_reg == PAR_W'(1));
                    pbuf_reg[0] <= '0;
                    for (int j = 1; j < MAX_PARITY; j++) begin
                        pbuf_reg[j] <= pbuf_reg[j-1];
                    end
                    pcnt_reg    <= pcnt_reg - PAR_W'(1);
                end else if (proc) begin
                    m_valid_reg <= 1'b1;
                    m_sym_reg   <= d_in;
                    m_par_reg   <= 1'b0;
                    m_last_reg  <= 1'b0;
                    if (word_end) begin
                        pbuf_reg  <= lfsr_next;
                        pcnt_reg  <= p_eff;
                        taken_reg <= '0;
                        for (int j = 0; j < MAX_PARITY; j++) begin
                            lfsr_reg[j] <= '0;
                        end
                    end else begin
                        lfsr_reg  <= lfsr_next;
                        taken_reg <= taken_inc;
                    end
                end else begin
                    m_valid_reg <= 1'b0;
                end
            end

            // a write to a mapped register restarts the generator build
            if (cfg_hit) begin
                unique case (reg_idx)
                    REG_SYMBOL_BITS:  sbits_reg  <= pwdata[3:0];
                    REG_FIELD_POLY:   fpoly_reg  <= pwdata[8:0];
                    REG_PARITY_COUNT: pcount_reg <= pwdata[5:0];
                    REG_MESSAGE_LEN:  mlen_reg   <= pwdata[7:0];
                    REG_FIRST_ROOT:   fcr_reg    <= pwdata[7:0];
                    default:          ;
                endcase
                state_reg <= ST_POW;
                step_reg  <= '0;
                root_reg  <= sym_t'(1);
                for (int j = 0; j <= MAX_PARITY; j++) begin
                    gen_reg[j] <= (j == 0) ? sym_t'(1) : '0;
                end
                for (int j = 0; j < MAX_PARITY; j++) begin
                    lfsr_reg[j] <= '0;
                end
                taken_reg <= '0;
            end else begin
                unique case (state_reg)
                    // walk root up to alpha^fcr
                    ST_POW: begin
                        if (step_reg == fcr_reg) begin
                            state_reg <= ST_GEN;
                            step_reg  <= '0;
                        end else begin
                            root_reg <= gf_xtime(root_reg, m_eff, fpoly_reg);
                            step_reg <= step_reg + 8'd1;
                        end
                    end
                    // one root factor per cycle
                    ST_GEN: begin
                        gen_reg  <= gen_next;
                        root_reg <= gf_xtime(root_reg, m_eff, fpoly_reg);
                        step_reg <= step_reg + 8'd1;
                        if (step_reg == 8'(p_last)) begin
                            state_reg <= ST_RUN;
                        end
                    end
                    ST_RUN: begin
                    end
                    default: state_reg <= ST_POW;
                endcase
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_symbol = m_sym_reg;
    assign m_is_parity  = m_par_reg;
    assign m_block_last = m_last_reg;

endmodule

/* tb/rse_codeword_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rse_codeword_checker
// Watches the configuration port and both streams of the Reed-Solomon encoder.
// It keeps its own copy of the registers, the generator and the parity LFSR,
// works out the codeword symbols that each accepted data symbol causes, and
// compares every output transaction with the oldest one still expected.
// ----------------------------------------------------------------------------
module rse_codeword_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input stream
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  rse_pkg::sym_t                    s_data_symbol,
    // output stream
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  rse_pkg::sym_t                    m_out_symbol,
    input  logic                             m_is_parity,
    input  logic                             m_block_last,
    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rse_pkg::RSE_ADDR_W-1:0]   paddr,
    input  logic [rse_pkg::RSE_DATA_W-1:0]   pwdata,
    input  logic                             pready,
    // status to the testbench top
    output int                               error_count,
    output int                               pending_results
);

    import rse_pkg::*;

    localparam sym_t ALPHA      = 8'd2;
    localparam int   MAX_REPORT = 10;

    typedef struct packed {
        sym_t symbol;
        logic parity;
        logic last;
    } cw_symbol_t;

    // shadow registers
    logic [3:0] cfg_bits;
    poly_t      cfg_poly;
    logic [5:0] cfg_parity;
    logic [7:0] cfg_len;
    logic [7:0] cfg_root;

    // encoder state
    sym_t       gen_coef [RSE_MAX_PARITY];
    sym_t       lfsr_q   [RSE_MAX_PARITY];
    logic [7:0] symbols_in;

    cw_symbol_t codeword_q[$];
    int         mismatches = 0;

    // effective m, P and k after saturation
    function automatic int field_bits();
        int m;
        m = cfg_bits;
        if (m < 3) m = 3;
        if (m > MAX_SYMBOL_BITS) m = MAX_SYMBOL_BITS;
        return m;
    endfunction

    function automatic int parity_len();
        int p;
        p = cfg_parity;
        if (p < 2) p = 2;
        if (p > RSE_MAX_PARITY) p = RSE_MAX_PARITY;
        return p;
    endfunction

    function automatic int msg_len();
        return (cfg_len == 8'd0) ? 1 : int'(cfg_len);
    endfunction

    // polynomial product modulo the field polynomial, m bits wide
    function automatic sym_t gf_times(sym_t a, sym_t b, int m, poly_t poly);
        logic [8:0] mask;
        logic [8:0] shifted;
        sym_t       prod;
        int         i;
        mask    = (9'd1 << m) - 9'd1;
        shifted = {1'b0, a} & mask;
        prod    = '0;
        for (i = 0; i < m; i++) begin
            if (b[i]) prod = prod ^ shifted[7:0];
            shifted = shifted << 1;
            if (shifted[m]) shifted = shifted ^ poly;
            shifted = shifted & mask;
        end
        return prod;
    endfunction

    // g(x) = prod (x - alpha^(fcr+i)); also clears the LFSR and the count
    task automatic derive_generator();
        sym_t g [RSE_MAX_PARITY+1];
        sym_t root;
        int   m, p, i, j;
        m = field_bits();
        p = parity_len();
        for (i = 0; i <= RSE_MAX_PARITY; i++) g[i] = '0;
        g[0] = 8'd1;
        root = 8'd1;
        for (i = 0; i < int'(cfg_root); i++) root = gf_times(root, ALPHA, m, cfg_poly);
        for (i = 0; i < p; i++) begin
            for (j = i + 1; j >= 1; j--)
                g[j] = g[j-1] ^ gf_times(root, g[j], m, cfg_poly);
            g[0] = gf_times(root, g[0], m, cfg_poly);
            root = gf_times(root, ALPHA, m, cfg_poly);
        end
        for (i = 0; i < RSE_MAX_PARITY; i++) begin
            gen_coef[i] = (i < p) ? g[i] : '0;
            lfsr_q[i]   = '0;
        end
        symbols_in = '0;
    endtask

    task automatic load_defaults();
        cfg_bits   = RST_SYMBOL_BITS;
        cfg_poly   = RST_FIELD_POLY;
        cfg_parity = RST_PARITY_COUNT;
        cfg_len    = RST_MESSAGE_LEN;
        cfg_root   = RST_FIRST_ROOT;
        derive_generator();
    endtask

    // register write; unmapped indexes leave everything alone
    task automatic apply_write(input logic [RSE_ADDR_W-1:0] addr,
                               input logic [RSE_DATA_W-1:0] data);
        logic hit;
        hit = 1'b1;
        case (addr[4:2])
            REG_SYMBOL_BITS:  cfg_bits   = data[3:0];
            REG_FIELD_POLY:   cfg_poly   = data[8:0];
            REG_PARITY_COUNT: cfg_parity = data[5:0];
            REG_MESSAGE_LEN:  cfg_len    = data[7:0];
            REG_FIRST_ROOT:   cfg_root   = data[7:0];
            default:          hit        = 1'b0;
        endcase
        if (hit) derive_generator();
    endtask

    // one data symbol in: pass-through symbol, then parity at codeword end
    task automatic encode_symbol(input sym_t data);
        cw_symbol_t item;
        sym_t       mask, d, fb;
        int         m, p, j;
        m    = field_bits();
        p    = parity_len();
        mask = sym_t'((9'd1 << m) - 9'd1);
        d    = data & mask;
        fb   = d ^ lfsr_q[p-1];

        item.symbol = d;
        item.parity = 1'b0;
        item.last   = 1'b0;
        codeword_q.push_back(item);

        for (j = p - 1; j >= 1; j--)
            lfsr_q[j] = lfsr_q[j-1] ^ gf_times(fb, gen_coef[j], m, cfg_poly);
        lfsr_q[0] = gf_times(fb, gen_coef[0], m, cfg_poly);

        symbols_in = symbols_in + 8'd1;
        if (int'(symbols_in) >= msg_len()) begin
            for (j = 0; j < p; j++) begin
                item.symbol = lfsr_q[p-1-j];
                item.parity = 1'b1;
                item.last   = (j == p - 1);
                codeword_q.push_back(item);
            end
            for (j = 0; j < RSE_MAX_PARITY; j++) lfsr_q[j] = '0;
            symbols_in = '0;
        end
    endtask

    task automatic check_result();
        cw_symbol_t want;
        if (codeword_q.size() == 0) begin
            if (mismatches < MAX_REPORT)
                $display("%0t: unexpected output sym %02h parity %0b last %0b",
                         $realtime, m_out_symbol, m_is_parity, m_block_last);
            mismatches++;
        end else begin
            want = codeword_q.pop_front();
            if (m_out_symbol !== want.symbol || m_is_parity !== want.parity ||
                m_block_last !== want.last) begin
                if (mismatches < MAX_REPORT)
                    $display("%0t: mismatch exp sym %02h parity %0b last %0b,",
                             $realtime, want.symbol, want.parity, want.last,
                             " got sym %02h parity %0b last %0b",
                             m_out_symbol, m_is_parity, m_block_last);
                mismatches++;
            end
        end
    endtask

    // sample every transaction at the clock edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            load_defaults();
            codeword_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) apply_write(paddr, pwdata);
            if (m_valid && m_ready) check_result();
            if (s_valid && s_ready) encode_symbol(s_data_symbol);
        end
        error_count     <= mismatches;
        pending_results <= codeword_q.size();
    end

endmodule

/* tb/tb_rs_systematic_encoder.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rs_systematic_encoder
// Drives the Reed-Solomon encoder through a directed set of codes (symbol
// widths, lengths and parity counts at and past their limits, odd field
// polynomials, codewords longer than the field, a write mid-codeword) and then
// random codes with random data under changing source and sink pacing. The
// checker beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_rs_systematic_encoder;

    import rse_pkg::*;

    localparam int         CLK_HALF      = 10;
    localparam int         RESET_CYCLES  = 11;
    localparam int         CYCLE_LIMIT   = 400000;
    localparam int         RANDOM_PHASES = 15;
    localparam int         SETTLE_BASE   = 40;
    localparam int         DRAIN_CYCLES  = 8;
    localparam logic [2:0] REG_SPARE     = 3'd5;

    typedef enum int {
        PACE_NONE,
        PACE_SEND_IDLE,
        PACE_RECV_STALL,
        PACE_BOTH
    } pacing_e;

    logic aclk = 1'b0;
    logic aresetn;

    logic                  s_valid;
    logic                  s_ready;
    sym_t                  s_data_symbol;
    logic                  m_valid;
    logic                  m_ready;
    sym_t                  m_out_symbol;
    logic                  m_is_parity;
    logic                  m_block_last;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [RSE_ADDR_W-1:0] paddr;
    logic [RSE_DATA_W-1:0] pwdata;
    logic [RSE_DATA_W-1:0] prdata;
    logic                  pready;

    int checker_errors;
    int checker_pending;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int root_now       = RST_FIRST_ROOT;
    int cycle_count    = 0;

    int         phase, count, n, eff_bits;
    logic [3:0] rnd_bits;
    poly_t      rnd_poly;
    logic [5:0] rnd_parity;
    logic [7:0] rnd_len;
    logic [7:0] rnd_root;

    always #CLK_HALF aclk = ~aclk;

    rs_systematic_encoder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_symbol (s_data_symbol),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_symbol  (m_out_symbol),
        .m_is_parity   (m_is_parity),
        .m_block_last  (m_block_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    rse_codeword_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_symbol   (s_data_symbol),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_symbol    (m_out_symbol),
        .m_is_parity     (m_is_parity),
        .m_block_last    (m_block_last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .error_count     (checker_errors),
        .pending_results (checker_pending)
    );

    // sink backpressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb_rs_systematic_encoder: done, errors");
        $finish;
    end

    task automatic set_pacing(input pacing_e mode);
        case (mode)
            PACE_NONE:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            PACE_SEND_IDLE:  begin send_idle_pct = 65; recv_stall_pct = 0;  end
            PACE_RECV_STALL: begin send_idle_pct = 0;  recv_stall_pct = 65; end
            default:         begin send_idle_pct = 7;  recv_stall_pct = 7;  end
        endcase
    endtask

    // one data symbol transaction, with random idle cycles ahead of it
    task automatic send_symbol(input sym_t value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_data_symbol <= value;
        do @(posedge aclk); while (!s_ready);
    endtask

    // stop sending and wait until every expected symbol has come out
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (checker_pending != 0) @(posedge aclk);
    endtask

    // APB write: setup then access; a pause first lets any rebuild finish
    task automatic reg_write(input logic [2:0] idx, input logic [RSE_DATA_W-1:0] value);
        repeat (SETTLE_BASE + root_now) @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic program_code(input logic [3:0] bits, input poly_t poly,
                                input logic [5:0] parity, input logic [7:0] len,
                                input logic [7:0] root);
        wait_idle();
        reg_write(REG_SYMBOL_BITS, RSE_DATA_W'(bits));
        reg_write(REG_FIELD_POLY, RSE_DATA_W'(poly));
        reg_write(REG_PARITY_COUNT, RSE_DATA_W'(parity));
        reg_write(REG_MESSAGE_LEN, RSE_DATA_W'(len));
        reg_write(REG_FIRST_ROOT, RSE_DATA_W'(root));
        root_now = root;
    endtask

    function automatic poly_t primitive_for(int m);
        case (m)
            3:       return 9'h00B;
            4:       return 9'h013;
            5:       return 9'h025;
            6:       return 9'h043;
            7:       return 9'h089;
            default: return 9'h11D;
        endcase
    endfunction

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data_symbol = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        set_pacing(PACE_NONE);

        // reset code, codeword left unfinished; the next write clears it
        send_symbol(8'h00);
        send_symbol(8'hFF);
        send_symbol(8'h5A);

        // smallest field, two codewords; high data bits masked off
        program_code(4'd3, 9'h00B, 6'd2, 8'd2, 8'd0);
        send_symbol(8'hFF);
        send_symbol(8'h00);
        send_symbol(8'h07);
        send_symbol(8'hF8);

        // width, parity and length below range, reducible polynomial
        program_code(4'd0, 9'h1FF, 6'd0, 8'd0, 8'd254);
        send_symbol(8'hAA);
        send_symbol(8'h55);

        // codeword longer than the field
        program_code(4'd4, 9'h013, 6'd6, 8'd10, 8'd1);
        for (n = 0; n < 10; n++) send_symbol(sym_t'($urandom_range(0, 255)));

        // width and parity above range, one-symbol message, largest root
        program_code(4'd15, 9'h11D, 6'd63, 8'd1, 8'd255);
        reg_write(REG_SPARE, $urandom());
        send_symbol(8'hFF);

        // longest message, full parity
        program_code(4'd8, 9'h11D, 6'd32, 8'd255, 8'd0);
        send_symbol(8'h80);
        send_symbol(8'h01);

        // random codes and data
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            rnd_bits = ($urandom_range(99) < 80) ? 4'($urandom_range(3, 8))
                                                 : 4'($urandom_range(0, 15));
            eff_bits = (rnd_bits < 3) ? 3 : ((rnd_bits > 8) ? 8 : int'(rnd_bits));
            rnd_poly = ($urandom_range(99) < 50) ? primitive_for(eff_bits)
                                                 : poly_t'($urandom_range(0, 511));
            rnd_parity = ($urandom_range(99) < 80) ? 6'($urandom_range(2, 32))
                                                   : 6'($urandom_range(0, 63));
            rnd_len = ($urandom_range(99) < 60) ? 8'($urandom_range(0, 12))
                                                : 8'($urandom_range(0, 255));
            rnd_root = 8'($urandom_range(0, 255));
            program_code(rnd_bits, rnd_poly, rnd_parity, rnd_len, rnd_root);

            set_pacing(pacing_e'(phase % 4));
            count = $urandom_range(20, 40);
            for (n = 0; n < count; n++) send_symbol(sym_t'($urandom_range(0, 255)));
        end

        // drain and verdict
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (checker_errors == 0 && checker_pending == 0) begin
            $display("tb_rs_systematic_encoder: done, clean");
        end else begin
            if (checker_pending != 0)
                $display("%0d codeword symbols never came out", checker_pending);
            $display("tb_rs_systematic_encoder: done, errors");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/rse_pkg.sv
sv/rs_systematic_encoder.sv
tb/rse_codeword_checker.sv
tb/tb_rs_systematic_encoder.sv
